>>> hdl/gcm_ghash_tag_engine_defines.svh
// assertion helpers for the engine's back end
// every check is sampled on aclk and held off while aresetn is low
`ifndef GCM_GHASH_TAG_ENGINE_DEFINES_SVH
`define GCM_GHASH_TAG_ENGINE_DEFINES_SVH

// same-cycle implication
`define GGTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GGTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ggte_pkg.sv
package ggte_pkg;

    localparam int BLOCK_BITS       = 128;
    localparam int BLOCK_BYTES      = 16;
    localparam int COUNT_W          = 61;
    localparam int MUL_BITS_PER_CYC = 8;
    localparam int MUL_CYCLES       = BLOCK_BITS / MUL_BITS_PER_CYC;
    localparam int MUL_CNT_W        = $clog2(MUL_CYCLES);
    localparam int GGTE_QUEUE_DEPTH = 2;

    localparam logic [7:0] GF_REDUCE = 8'he1;

    // input modes
    localparam logic [1:0] MODE_AAD    = 2'd0;
    localparam logic [1:0] MODE_TEXT   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // command kinds between front and back
    localparam logic [2:0] KIND_AAD    = 3'd0;
    localparam logic [2:0] KIND_TEXT   = 3'd1;
    localparam logic [2:0] KIND_FINISH = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_HKEY_HI  = 2'd0;
    localparam logic [1:0] CFG_HKEY_LO  = 2'd1;
    localparam logic [1:0] CFG_TMASK_HI = 2'd2;
    localparam logic [1:0] CFG_TMASK_LO = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
        logic [4:0]  byte_count;
    } in_t;

    typedef struct packed {
        logic [63:0] hash_hi;
        logic [63:0] hash_lo;
        logic        is_tag;
    } out_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [BLOCK_BITS-1:0] data;
        logic [4:0]            nbytes;
    } cmd_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] hkey;
        logic [BLOCK_BITS-1:0] tmask;
    } key_t;

endpackage

>>> hdl/ggte_front.sv
module ggte_front
    import ggte_pkg::*;
(
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_item,
    output logic cmd_valid,
    input  logic cmd_ready,
    output cmd_t cmd
);

    logic [4:0]            nsat;
    logic [BLOCK_BITS-1:0] mask;

    // saturate the byte count to a whole block
    assign nsat = (in_item.byte_count > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES)
                                                         : in_item.byte_count;

    // keep the leading valid bytes, byte 0 at the top
    always_comb begin
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            mask[BLOCK_BITS-1-8*i -: 8] = (5'(i) < nsat) ? 8'hff : 8'h00;
        end
    end

    // classify the item into a command for the back end
    always_comb begin
        cmd.data   = {in_item.block_hi, in_item.block_lo} & mask;
        cmd.nbytes = nsat;
        case (in_item.mode)
            MODE_AAD:    cmd.kind = (nsat == 5'd0) ? KIND_READ : KIND_AAD;
            MODE_TEXT:   cmd.kind = (nsat == 5'd0) ? KIND_READ : KIND_TEXT;
            MODE_FINISH: cmd.kind = KIND_FINISH;
            default:     cmd.kind = KIND_CLEAR;
        endcase
    end

    assign cmd_valid = in_valid;
    assign in_ready  = cmd_ready;

endmodule

>>> hdl/ggte_queue.sv
module ggte_queue
    import ggte_pkg::*;
#(
    parameter int DEPTH = GGTE_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> hdl/ggte_back.sv
`include "gcm_ghash_tag_engine_defines.svh"

module ggte_back
    import ggte_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  key_t key,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [MUL_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  fin_reg, fin_next;
    logic [BLOCK_BITS-1:0] x_reg, x_next;
    logic [BLOCK_BITS-1:0] v_reg, v_next;
    logic [BLOCK_BITS-1:0] z_reg, z_next;
    logic [BLOCK_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0]    aad_reg, aad_next;
    logic [COUNT_W-1:0]    txt_reg, txt_next;
    logic [BLOCK_BITS-1:0] res_reg, res_next;
    logic                  res_tag_reg, res_tag_next;
    out_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BLOCK_BITS-1:0] zm, vm;
    logic                  lsb;
    logic                  pop;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // eight bits of the X operand of the GF(2^128) product per cycle
    always_comb begin
        zm  = z_reg;
        vm  = v_reg;
        lsb = 1'b0;
        for (int k = 0; k < MUL_BITS_PER_CYC; k++) begin
            if (x_reg[BLOCK_BITS-1-k]) begin
                zm = zm ^ vm;
            end
            lsb = vm[0];
            vm  = {1'b0, vm[BLOCK_BITS-1:1]};
            if (lsb) begin
                vm[BLOCK_BITS-1 -: 8] = vm[BLOCK_BITS-1 -: 8] ^ GF_REDUCE;
            end
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        x_next         = x_reg;
        v_next         = v_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        aad_next       = aad_reg;
        txt_next       = txt_reg;
        res_next       = res_reg;
        res_tag_next   = res_tag_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    v_next   = key.hkey;
                    z_next   = '0;
                    cnt_next = '0;
                    fin_next = 1'b0;
                    case (cmd.kind)
                        KIND_AAD: begin
                            x_next     = acc_reg ^ cmd.data;
                            aad_next   = aad_reg + COUNT_W'(cmd.nbytes);
                            state_next = ST_MUL;
                        end
                        KIND_TEXT: begin
                            x_next     = acc_reg ^ cmd.data;
                            txt_next   = txt_reg + COUNT_W'(cmd.nbytes);
                            state_next = ST_MUL;
                        end
                        KIND_FINISH: begin
                            x_next     = acc_reg ^ {aad_reg, 3'b000, txt_reg, 3'b000};
                            fin_next   = 1'b1;
                            state_next = ST_MUL;
                        end
                        KIND_CLEAR: begin
                            acc_next     = '0;
                            aad_next     = '0;
                            txt_next     = '0;
                            res_next     = '0;
                            res_tag_next = 1'b0;
                            state_next   = ST_HOLD;
                        end
                        default: begin
                            res_next     = acc_reg;
                            res_tag_next = 1'b0;
                            state_next   = ST_HOLD;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                x_next   = x_reg << MUL_BITS_PER_CYC;
                v_next   = vm;
                z_next   = zm;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_CYCLES - 1)) begin
                    if (fin_reg) begin
                        res_next     = zm ^ key.tmask;
                        res_tag_next = 1'b1;
                        acc_next     = '0;
                        aad_next     = '0;
                        txt_next     = '0;
                    end else begin
                        res_next     = zm;
                        res_tag_next = 1'b0;
                        acc_next     = zm;
                    end
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!out_valid_reg || out_ready) begin
                    out_next.hash_hi = res_reg[BLOCK_BITS-1:64];
                    out_next.hash_lo = res_reg[63:0];
                    out_next.is_tag  = res_tag_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and hash state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            acc_reg       <= '0;
            aad_reg       <= '0;
            txt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            acc_reg       <= acc_next;
            aad_reg       <= aad_next;
            txt_reg       <= txt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        v_reg       <= v_next;
        z_reg       <= z_next;
        res_reg     <= res_next;
        res_tag_reg <= res_tag_next;
        out_reg     <= out_next;
    end

    `GGTE_ASSERT_NEXT(a_mul_count, (state_reg == ST_MUL && cnt_reg != MUL_CNT_W'(MUL_CYCLES - 1)), (state_reg == ST_MUL && cnt_reg == MUL_CNT_W'($past(cnt_reg) + 1'b1)), "multiply sequence broke early")
    `GGTE_ASSERT_NEXT(a_finish_clears, (state_reg == ST_MUL && fin_reg && cnt_reg == MUL_CNT_W'(MUL_CYCLES - 1)), (acc_reg == '0 && aad_reg == '0 && txt_reg == '0 && res_tag_reg), "finish left state behind")
    `GGTE_ASSERT_NEXT(a_hold_stall, (state_reg == ST_HOLD && out_valid_reg && !out_ready), (state_reg == ST_HOLD), "result dropped while output stalled")
    `GGTE_ASSERT_NOW(a_out_from_hold, ($rose(out_valid_reg)), ($past(state_reg) == ST_HOLD), "output raised outside hold")

endmodule

>>> hdl/gcm_ghash_tag_engine.sv
// GCM GHASH tag engine. Each item carries a 128-bit block and a mode
// (additional data, ciphertext, finish, clear); every item gives exactly one
// result. A data block is cut to its leading byte_count bytes (counts above 16
// act as 16), XORed into the running hash and multiplied by H. The multiply
// takes eight bits of the operand per cycle. A data or finish item passes a load,
// the multiply and a hold that hands the result to the output register, waiting
// while it stalls; clear and empty blocks skip the multiply. A two-entry command
// queue in front lets new items be accepted while a block is in the multiplier.
// Finish folds in the length block, XORs E(K,J0) from tag_mask and clears the
// hash and byte counts. Write H and the tag mask only while no item is pending.
module gcm_ghash_tag_engine
    import ggte_pkg::*;
#(
    parameter int QUEUE_DEPTH = GGTE_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] hkey_hi_reg, hkey_lo_reg, tmask_hi_reg, tmask_lo_reg;
    key_t        key;
    logic        f_valid, f_ready;
    cmd_t        f_cmd;
    logic        q_valid, q_ready;
    cmd_t        q_cmd;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hkey_hi_reg  <= '0;
            hkey_lo_reg  <= '0;
            tmask_hi_reg <= '0;
            tmask_lo_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HKEY_HI:  hkey_hi_reg  <= cfg_data;
                CFG_HKEY_LO:  hkey_lo_reg  <= cfg_data;
                CFG_TMASK_HI: tmask_hi_reg <= cfg_data;
                CFG_TMASK_LO: tmask_lo_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign key.hkey  = {hkey_hi_reg, hkey_lo_reg};
    assign key.tmask = {tmask_hi_reg, tmask_lo_reg};

    ggte_front u_front (
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    ggte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_cmd   (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    ggte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key       (key),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

endmodule
